// ===== design/shortest_remaining_time_scheduler_macros.svh =====
// Assertion macros for the shortest-remaining-time scheduler.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SRTS_CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, checked out of reset.
`define SRTS_CHK_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ===== design/srts_pkg.sv =====
// Shared types and constants for the shortest-remaining-time scheduler.
// No dependencies; used by the top level and the testbench.
package srts_pkg;

	// Field widths fixed by the transaction format.
	localparam int ID_W   = 8;
	localparam int TIME_W = 16;

	// Default table depth.
	localparam int MAX_TASKS_DEF = 16;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Saturating count of entries with work left: zero, one, many.
	typedef logic [1:0] nz_cnt_t;
	localparam nz_cnt_t NZ_NONE = 2'd0;
	localparam nz_cnt_t NZ_ONE  = 2'd1;
	localparam nz_cnt_t NZ_MANY = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

// ===== design/shortest_remaining_time_scheduler.sv =====
// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// req     | req_valid, req_stall, cmd, task_id,             | in
//         | burst_len, arrival_tick                         |
// rsp     | rsp_valid, rsp_stall, ran_valid, ran_id,        | out
//         | finish_tick, task_finished, all_done, load_full |
//
// A load is handled in the idle state. A tick scans every loaded entry through
// the single table read port and the one remaining-time comparator that visits
// each entry in turn.
// Reset clears the sequencer, counters and ready bits; the table RAM holds
// no reset value. A stalled result holds the next transaction off.
`include "shortest_remaining_time_scheduler_macros.svh"

module shortest_remaining_time_scheduler #(
	parameter int MAX_TASKS = srts_pkg::MAX_TASKS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      cmd,
	input  logic [srts_pkg::ID_W-1:0]   task_id,
	input  logic [srts_pkg::TIME_W-1:0] burst_len,
	input  logic [srts_pkg::TIME_W-1:0] arrival_tick,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      ran_valid,
	output logic [srts_pkg::ID_W-1:0]   ran_id,
	output logic [srts_pkg::TIME_W-1:0] finish_tick,
	output logic                      task_finished,
	output logic                      all_done,
	output logic                      load_full
);

	import srts_pkg::*;

	localparam int IW     = $clog2(MAX_TASKS);
	localparam int CW     = $clog2(MAX_TASKS + 1);
	localparam int WORD_W = ID_W + 2 * TIME_W + IW;
	localparam int REM_LO = ID_W;
	localparam int ARR_LO = ID_W + TIME_W;
	localparam int RNK_LO = ID_W + 2 * TIME_W;

	// Sequencer and counters.
	state_t              state_q, state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       admit_q;
	logic [TIME_W-1:0]   tick_q;
	logic [CW-1:0]       idx_q;
	logic [MAX_TASKS-1:0] ready_q;

	// Read pipeline stage.
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;

	// Best candidate so far in the current tick.
	logic                best_vld_q;
	logic [IW-1:0]       best_idx_q;
	logic [ID_W-1:0]     best_id_q;
	logic [TIME_W-1:0]   best_rem_q;
	logic [TIME_W-1:0]   best_arr_q;
	logic [IW-1:0]       best_rank_q;
	nz_cnt_t             nz_q;

	// Result register.
	logic                rsp_valid_q;
	logic                ran_valid_q;
	logic [ID_W-1:0]     ran_id_q;
	logic [TIME_W-1:0]   finish_q;
	logic                finished_q;
	logic                done_q;
	logic                full_q;

	// Table RAM ports.
	logic                we;
	logic [IW-1:0]       waddr;
	logic [WORD_W-1:0]   wdata;
	logic                rd_issue;
	logic [WORD_W-1:0]   rdata;

	// Handshake and sequencing strobes.
	logic                req_go;
	logic                load_go;
	logic                tick_go;
	logic                slot_free;
	logic                fin_go;
	logic                tbl_full;

	// Fields of the entry under evaluation.
	logic [ID_W-1:0]     e_id;
	logic [TIME_W-1:0]   e_rem;
	logic [TIME_W-1:0]   e_arr;
	logic [IW-1:0]       e_rank;
	logic                e_rdy;
	logic                e_admit;
	logic [IW-1:0]       e_rank_eff;
	logic                e_cand;
	logic                e_better;
	logic                best_last;

	srts_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_issue),
		.raddr (idx_q[IW-1:0]),
		.rdata (rdata)
	);

	// Handshake strobes.
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !slot_free;
	assign req_go    = req_valid && !req_stall;
	assign load_go   = req_go && (cmd == CMD_LOAD);
	assign tick_go   = req_go && (cmd == CMD_TICK);
	assign tbl_full  = (count_q == CW'(MAX_TASKS));
	assign fin_go    = (state_q == ST_FIN) && slot_free;

	// Entry evaluation: admission and comparison against the best so far.
	assign e_id       = rdata[REM_LO-1:0];
	assign e_rem      = rdata[ARR_LO-1:REM_LO];
	assign e_arr      = rdata[RNK_LO-1:ARR_LO];
	assign e_rank     = rdata[WORD_W-1:RNK_LO];
	assign e_rdy      = ready_q[idx_s1];
	assign e_admit    = !e_rdy && (e_rem != '0) && (e_arr == tick_q);
	assign e_rank_eff = e_admit ? admit_q[IW-1:0] : e_rank;
	assign e_cand     = (e_rdy || e_admit) && (e_rem != '0);
	assign e_better   = !best_vld_q || (e_rem < best_rem_q) ||
		((e_rem == best_rem_q) && (e_rank_eff > best_rank_q));
	assign best_last  = best_vld_q && (best_rem_q == TIME_W'(1));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!rd_issue) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output logic: table read issue and the write port mux.
	always_comb begin
		rd_issue = 1'b0;
		we       = 1'b0;
		waddr    = count_q[IW-1:0];
		wdata    = {{IW{1'b0}}, arrival_tick, burst_len, task_id};
		unique case (state_q)
			ST_IDLE: begin
				we = load_go && !tbl_full;
			end
			ST_SCAN: begin
				rd_issue = (idx_q != count_q);
				we       = vld_s1 && e_admit;
				waddr    = idx_s1;
				wdata    = {e_rank_eff, e_arr, e_rem, e_id};
			end
			ST_FIN: begin
				we    = fin_go && best_vld_q;
				waddr = best_idx_q;
				wdata = {best_rank_q, best_arr_q, best_rem_q - TIME_W'(1), best_id_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer state, counters, ready bits and read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			admit_q <= '0;
			tick_q  <= '0;
			idx_q   <= '0;
			ready_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;
			if (load_go && !tbl_full) begin
				count_q                   <= count_q + CW'(1);
				ready_q[count_q[IW-1:0]]  <= 1'b0;
			end
			if (tick_go) begin
				idx_q <= '0;
			end else if (rd_issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (vld_s1 && e_admit) begin
				ready_q[idx_s1] <= 1'b1;
				admit_q         <= admit_q + CW'(1);
			end
			if (fin_go) begin
				tick_q <= tick_q + TIME_W'(1);
			end
		end
	end

	// Index of the entry arriving from the table.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
	end

	// Best-candidate tracking over one tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
			nz_q       <= NZ_NONE;
		end else if (tick_go) begin
			best_vld_q <= 1'b0;
			nz_q       <= NZ_NONE;
		end else if (vld_s1) begin
			if (e_cand && e_better) begin
				best_vld_q <= 1'b1;
			end
			if (e_rem != '0) begin
				nz_q <= (nz_q == NZ_NONE) ? NZ_ONE : NZ_MANY;
			end
		end
	end

	// Payload of the best candidate.
	always_ff @(posedge clk) begin
		if (vld_s1 && e_cand && e_better) begin
			best_idx_q  <= idx_s1;
			best_id_q   <= e_id;
			best_rem_q  <= e_rem;
			best_arr_q  <= e_arr;
			best_rank_q <= e_rank_eff;
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_go || fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_go) begin
			ran_valid_q <= 1'b0;
			ran_id_q    <= '0;
			finish_q    <= '0;
			finished_q  <= 1'b0;
			done_q      <= 1'b0;
			full_q      <= tbl_full;
		end else if (fin_go) begin
			ran_valid_q <= best_vld_q;
			ran_id_q    <= best_vld_q ? best_id_q : '0;
			finish_q    <= tick_q + TIME_W'(1);
			finished_q  <= best_last;
			done_q      <= (nz_q == NZ_NONE) || ((nz_q == NZ_ONE) && best_last);
			full_q      <= 1'b0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign ran_valid     = ran_valid_q;
	assign ran_id        = ran_id_q;
	assign finish_tick   = finish_q;
	assign task_finished = finished_q;
	assign all_done      = done_q;
	assign load_full     = full_q;

	// Table never holds more entries than it has rows, nor admits more than loaded.
	`SRTS_CHK_NOW(a_count_bound, 1'b1, (count_q <= CW'(MAX_TASKS)) && (admit_q <= count_q))
	// The tick counter moves only when a tick result is issued.
	`SRTS_CHK_NXT(a_tick_hold, !fin_go, $stable(tick_q))
	// A completion is only reported for a task that actually ran.
	`SRTS_CHK_NOW(a_finish_ran, rsp_valid_q && finished_q, ran_valid_q && !full_q)
	// The scan never reads past the loaded entries.
	`SRTS_CHK_NOW(a_scan_bound, state_q == ST_SCAN, idx_q <= count_q)

endmodule

// ===== design/srts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used by the scheduler for its task table.
module srts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/tb_shortest_remaining_time_scheduler.sv =====
// Self-checking testbench for the shortest-remaining-time scheduler.
// Depends on srts_pkg and the shortest_remaining_time_scheduler RTL; it checks every
// response against a built-in scheduling predictor.
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler;
	import srts_pkg::*;

	localparam int QUIET_TAIL = 150;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic              cmd;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] arrival;
	} sched_cmd_t;

	typedef struct packed {
		logic              ran_valid;
		logic [ID_W-1:0]   ran_id;
		logic [TIME_W-1:0] finish_tick;
		logic              task_finished;
		logic              all_done;
		logic              load_full;
	} sched_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic cmd = CMD_LOAD;
	logic [ID_W-1:0] task_id = '0;
	logic [TIME_W-1:0] burst_len = '0;
	logic [TIME_W-1:0] arrival_tick = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic ran_valid;
	logic [ID_W-1:0] ran_id;
	logic [TIME_W-1:0] finish_tick;
	logic task_finished;
	logic all_done;
	logic load_full;
	logic quiet = 1'b0;

	// Commands waiting to be sent and responses the predictor has computed.
	sched_cmd_t sched_cmds[$];
	sched_rsp_t predicted_rsp[$];
	int mismatches = 0;
	int send_gap = 0;
	int stall_left = 0;

	// Generator bookkeeping: ticks issued and table entries used so far.
	int gen_tick = 0;
	int gen_loaded = 0;

	// Predictor copy of the task table.
	logic [ID_W-1:0]   tbl_id[MAX_TASKS_DEF];
	logic [TIME_W-1:0] tbl_left[MAX_TASKS_DEF];
	logic [TIME_W-1:0] tbl_arrival[MAX_TASKS_DEF];
	logic              tbl_ready[MAX_TASKS_DEF];
	int                tbl_rank[MAX_TASKS_DEF];
	int                tbl_count = 0;
	int                admitted = 0;
	logic [TIME_W-1:0] now_tick = '0;

	shortest_remaining_time_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.task_id      (task_id),
		.burst_len    (burst_len),
		.arrival_tick (arrival_tick),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.ran_valid    (ran_valid),
		.ran_id       (ran_id),
		.finish_tick  (finish_tick),
		.task_finished(task_finished),
		.all_done     (all_done),
		.load_full    (load_full)
	);

	always #1 clk = ~clk;

	// Applies one command to the predicted table and returns the response it causes.
	function automatic sched_rsp_t srtf_step(input sched_cmd_t rq);
		sched_rsp_t r;
		int pick;
		r = '0;
		pick = -1;
		if (rq.cmd == CMD_LOAD) begin
			if (tbl_count >= MAX_TASKS_DEF) begin
				r.load_full = 1'b1;
			end else begin
				tbl_id[tbl_count] = rq.id;
				tbl_left[tbl_count] = rq.burst;
				tbl_arrival[tbl_count] = rq.arrival;
				tbl_ready[tbl_count] = 1'b0;
				tbl_rank[tbl_count] = 0;
				tbl_count++;
			end
			return r;
		end
		// Admit tasks arriving now that still have work.
		for (int i = 0; i < tbl_count; i++) begin
			if (!tbl_ready[i] && tbl_left[i] != 0 && tbl_arrival[i] == now_tick) begin
				tbl_ready[i] = 1'b1;
				tbl_rank[i] = admitted;
				admitted++;
			end
		end
		// Least remaining wins; on a tie the later admission wins.
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_ready[i] && tbl_left[i] != 0 && (pick < 0 || tbl_left[i] < tbl_left[pick] ||
					(tbl_left[i] == tbl_left[pick] && tbl_rank[i] > tbl_rank[pick])))
				pick = i;
		end
		now_tick = now_tick + 1'b1;
		r.finish_tick = now_tick;
		if (pick >= 0) begin
			tbl_left[pick] = tbl_left[pick] - 1'b1;
			r.ran_valid = 1'b1;
			r.ran_id = tbl_id[pick];
			r.task_finished = (tbl_left[pick] == 0);
		end
		r.all_done = 1'b1;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_left[i] != 0)
				r.all_done = 1'b0;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	task automatic add_load(input int id, input int burst, input int arrival);
		sched_cmd_t c;
		c.cmd = CMD_LOAD;
		c.id = id[ID_W-1:0];
		c.burst = burst[TIME_W-1:0];
		c.arrival = arrival[TIME_W-1:0];
		sched_cmds.push_back(c);
		if (gen_loaded < MAX_TASKS_DEF)
			gen_loaded++;
	endtask

	// Tick transactions carry random values in the unused fields.
	task automatic add_tick();
		sched_cmd_t c;
		c.cmd = CMD_TICK;
		c.id = ID_W'($urandom);
		c.burst = TIME_W'($urandom);
		c.arrival = TIME_W'($urandom);
		sched_cmds.push_back(c);
		gen_tick++;
	endtask

	// Request driver: predicts each accepted transaction, then presents the next one.
	always @(posedge clk or negedge arst_n) begin
		sched_cmd_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			cmd <= CMD_LOAD;
			task_id <= '0;
			burst_len <= '0;
			arrival_tick <= '0;
			quiet <= 1'b0;
			send_gap = 0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				predicted_rsp.push_back(srtf_step({cmd, task_id, burst_len, arrival_tick}));
			quiet <= (sched_cmds.size() < QUIET_TAIL);
			if (send_gap > 0 || sched_cmds.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				req_valid <= 1'b0;
			end else begin
				nxt = sched_cmds.pop_front();
				req_valid <= 1'b1;
				cmd <= nxt.cmd;
				task_id <= nxt.id;
				burst_len <= nxt.burst;
				arrival_tick <= nxt.arrival;
				if (sched_cmds.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 8);
			end
		end
	end

	// Response monitor: checks each accepted transaction and stalls in random bursts.
	always @(posedge clk or negedge arst_n) begin
		sched_rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp.size() == 0) begin
					$error("response with no prediction pending");
					mismatches++;
				end else begin
					want = predicted_rsp.pop_front();
					check_field("ran_valid", int'(want.ran_valid), int'(ran_valid));
					check_field("ran_id", int'(want.ran_id), int'(ran_id));
					check_field("finish_tick", int'(want.finish_tick), int'(finish_tick));
					check_field("task_finished", int'(want.task_finished),
						int'(task_finished));
					check_field("all_done", int'(want.all_done), int'(all_done));
					check_field("load_full", int'(want.load_full), int'(load_full));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int n;
		// Empty table, a zero-burst task, then a tie and a preemption.
		add_tick();
		add_load('h00, 'h0000, 'hFFFF);
		add_tick();
		add_load('h11, 3, gen_tick);
		add_load('h22, 3, gen_tick);
		add_load('h33, 1, gen_tick + 2);
		repeat (9) add_tick();

		// Random phase: clusters of near-future arrivals between runs of ticks.
		while (sched_cmds.size() < 1700) begin
			if (gen_loaded < 14 && $urandom_range(0, 59) == 0) begin
				n = $urandom_range(1, 3);
				for (int k = 0; k < n && gen_loaded < 14; k++)
					add_load($urandom_range(0, 255),
						($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 80),
						gen_tick + $urandom_range(0, 24));
			end else begin
				add_tick();
			end
		end
		while (gen_loaded < 14)
			add_load($urandom_range(0, 255), $urandom_range(1, 40), gen_tick);

		// A task whose arrival has already gone by, then the longest possible burst.
		add_load($urandom_range(0, 255), $urandom_range(1, 5), gen_tick - 1);
		repeat (2) add_tick();
		add_load('hFF, 'hFFFF, gen_tick);
		add_tick();

		// Full table: refused loads mixed with ticks.
		add_load('h00, 'h0000, 'h0000);
		add_load('hFF, 'hFFFF, 'hFFFF);
		for (int k = 0; k < 60; k++) begin
			if ($urandom_range(0, 1) == 0)
				add_load($urandom_range(0, 255), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			else
				add_tick();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (sched_cmds.size() != 0 || req_valid || predicted_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#(1_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
